// ----- src/evtmr_pkg.sv -----
// Shared types, codes and register map constants for the event timer block.
package evtmr_pkg;

   localparam int NUM_TIMERS_DEF = 3;
   localparam int DATA_W         = 64;
   localparam int WORD_W         = 7;
   localparam int PERIOD_W       = 27;
   localparam int MASK_W         = 3;
   localparam int TIMER_SEL_W    = 5;
   localparam int ROUTE_W        = 5;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = 27'd10000000;
   localparam logic [0:0]          CSR_TICK_PERIOD   = 1'd0;

   localparam logic [WORD_W-1:0] W_CAPS   = 7'd0;
   localparam logic [WORD_W-1:0] W_GCONF  = 7'd2;
   localparam logic [WORD_W-1:0] W_COUNT  = 7'd30;
   localparam logic [WORD_W-1:0] W_TIMER0 = 7'd32;

   localparam logic [1:0] SUB_CONFIG  = 2'd0;
   localparam logic [1:0] SUB_COMPARE = 2'd1;

   localparam int GCONF_EN_BIT     = 0;
   localparam int GCONF_LEGACY_BIT = 1;
   localparam int TCFG_EN_BIT      = 2;
   localparam int TCFG_PER_BIT     = 3;
   localparam int TCFG_SETV_BIT    = 6;
   localparam int TCFG_ROUTE_LSB   = 9;
   localparam int CAPS_LAST_LSB    = 8;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_WRITE = 2'd2
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [WORD_W-1:0] word_index;
      logic [DATA_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic [MASK_W-1:0] fired_mask;
   } rsp_type;

   typedef struct packed {
      logic [ROUTE_W-1:0] route;
      logic               setv;
      logic               per;
      logic               en;
   } timer_ctrl_type;

   typedef struct packed {
      logic tick;
      logic wr_cfg;
      logic wr_cmp;
   } timer_cmd_type;

   typedef struct packed {
      logic              fire;
      logic [DATA_W-1:0] cfg_word;
      logic [DATA_W-1:0] compare;
   } timer_status_type;

endpackage

// ----- src/evtmr_timer.sv -----
// One comparator timer: control word, comparator, period and match logic.
module evtmr_timer (
   input  logic                                clock,
   input  logic                                reset,
   input  evtmr_pkg::timer_cmd_type            cmd,
   input  logic [evtmr_pkg::DATA_W-1:0]        count_next,
   input  logic [evtmr_pkg::DATA_W-1:0]        wr_value,
   output evtmr_pkg::timer_status_type         status
);

   evtmr_pkg::timer_ctrl_type          ctrl_ff, ctrl_in;
   logic [evtmr_pkg::DATA_W-1:0]       compare_ff, compare_in;
   logic [evtmr_pkg::DATA_W-1:0]       period_ff, period_in;
   logic                               hit;

   assign hit = cmd.tick && (count_next == compare_ff);

   always_comb begin
      ctrl_in    = ctrl_ff;
      compare_in = compare_ff;
      period_in  = period_ff;
      if (cmd.wr_cfg) begin
         ctrl_in.en    = wr_value[evtmr_pkg::TCFG_EN_BIT];
         ctrl_in.per   = wr_value[evtmr_pkg::TCFG_PER_BIT];
         ctrl_in.setv  = wr_value[evtmr_pkg::TCFG_SETV_BIT];
         ctrl_in.route = wr_value[evtmr_pkg::TCFG_ROUTE_LSB +: evtmr_pkg::ROUTE_W];
      end else if (cmd.wr_cmp) begin
         period_in = wr_value;
         if (!ctrl_ff.per || ctrl_ff.setv) begin
            compare_in = wr_value;
         end
         ctrl_in.setv = 1'b0;
      end else if (hit && ctrl_ff.per) begin
         compare_in = compare_ff + period_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff    <= '0;
         compare_ff <= '1;
         period_ff  <= '0;
      end else begin
         ctrl_ff    <= ctrl_in;
         compare_ff <= compare_in;
         period_ff  <= period_in;
      end
   end

   always_comb begin
      status.fire     = hit && ctrl_ff.en;
      status.compare  = compare_ff;
      status.cfg_word = '0;
      status.cfg_word[evtmr_pkg::TCFG_EN_BIT]   = ctrl_ff.en;
      status.cfg_word[evtmr_pkg::TCFG_PER_BIT]  = ctrl_ff.per;
      status.cfg_word[evtmr_pkg::TCFG_SETV_BIT] = ctrl_ff.setv;
      status.cfg_word[evtmr_pkg::TCFG_ROUTE_LSB +: evtmr_pkg::ROUTE_W] = ctrl_ff.route;
   end

endmodule

// ----- src/event_timer_with_comparators.sv -----
// Top level of the event timer: main counter, register decode and beat pipeline.
// A beat is taken into the input register, processed, and its result is held in the result register.
// Throughput: one tick or register access per cycle unless rsp_stall holds the result;
// the counter increment and all comparator matches are resolved in the single processing stage.
// Reset is synchronous and active high: counter, enables and timer controls go
// to zero, comparators to all ones, and the tick period to its default.
module event_timer_with_comparators #(
   parameter int NUM_TIMERS = evtmr_pkg::NUM_TIMERS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  evtmr_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output evtmr_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [evtmr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [evtmr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [evtmr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam logic [evtmr_pkg::TIMER_SEL_W-1:0] LAST_TIMER =
      evtmr_pkg::TIMER_SEL_W'((NUM_TIMERS - 1) & 31);

   // Configuration port.
   logic [evtmr_pkg::PERIOD_W-1:0] tick_period_ff, tick_period_in;
   logic [0:0]                     csr_index;
   logic                           csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[evtmr_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tick_period_in = tick_period_ff;
      if (csr_write && (csr_index == evtmr_pkg::CSR_TICK_PERIOD)) begin
         tick_period_in = csr_pwdata[evtmr_pkg::PERIOD_W-1:0];
      end
   end

   assign csr_prdata = (csr_index == evtmr_pkg::CSR_TICK_PERIOD) ?
      {{(evtmr_pkg::CSR_DATA_W - evtmr_pkg::PERIOD_W){1'b0}}, tick_period_ff} : '0;

   // Beat pipeline: input register, processing, result register.
   logic               in_valid_ff, in_valid_in;
   evtmr_pkg::req_type in_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   evtmr_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic               accept, advance;

   assign advance     = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Decode of the beat in the input register.
   logic [evtmr_pkg::WORD_W-1:0]      word;
   logic [evtmr_pkg::WORD_W-1:0]      word_off;
   logic                              is_timer;
   logic [evtmr_pkg::TIMER_SEL_W-1:0] timer_sel;
   logic [1:0]                        sub;
   logic                              do_tick, do_read, do_write;

   assign word      = in_data_ff.word_index;
   assign word_off  = word - evtmr_pkg::W_TIMER0;
   assign is_timer  = (word >= evtmr_pkg::W_TIMER0);
   assign timer_sel = word_off[evtmr_pkg::WORD_W-1:2];
   assign sub       = word_off[1:0];

   // Main counter and general configuration.
   logic                         global_enable_ff, global_enable_in;
   logic                         legacy_route_ff, legacy_route_in;
   logic [evtmr_pkg::DATA_W-1:0] main_count_ff, main_count_in;
   logic [evtmr_pkg::DATA_W-1:0] count_next;

   assign do_tick  = advance && (in_data_ff.func == evtmr_pkg::FUNC_TICK) && global_enable_ff;
   assign do_read  = in_data_ff.func == evtmr_pkg::FUNC_READ;
   assign do_write = advance && (in_data_ff.func == evtmr_pkg::FUNC_WRITE);
   assign count_next = main_count_ff + 64'd1;

   always_comb begin
      global_enable_in = global_enable_ff;
      legacy_route_in  = legacy_route_ff;
      main_count_in    = main_count_ff;
      if (do_tick) begin
         main_count_in = count_next;
      end else if (do_write && (word == evtmr_pkg::W_GCONF)) begin
         global_enable_in = in_data_ff.write_value[evtmr_pkg::GCONF_EN_BIT];
         legacy_route_in  = in_data_ff.write_value[evtmr_pkg::GCONF_LEGACY_BIT];
      end else if (do_write && (word == evtmr_pkg::W_COUNT)) begin
         main_count_in = in_data_ff.write_value;
      end
   end

   // Timers.
   evtmr_pkg::timer_status_type  timer_status [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]        timer_hit_sel;
   logic [evtmr_pkg::MASK_W-1:0] fired;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
      evtmr_pkg::timer_cmd_type cmd;

      assign timer_hit_sel[i] = is_timer && (timer_sel == evtmr_pkg::TIMER_SEL_W'(i));
      assign cmd.tick   = do_tick;
      assign cmd.wr_cfg = do_write && timer_hit_sel[i] && (sub == evtmr_pkg::SUB_CONFIG);
      assign cmd.wr_cmp = do_write && timer_hit_sel[i] && (sub == evtmr_pkg::SUB_COMPARE);

      evtmr_timer u_timer (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .count_next (count_next),
         .wr_value   (in_data_ff.write_value),
         .status     (timer_status[i])
      );
   end

   for (genvar j = 0; j < evtmr_pkg::MASK_W; j++) begin : g_mask
      if (j < NUM_TIMERS) begin : g_on
         assign fired[j] = timer_status[j].fire;
      end else begin : g_off
         assign fired[j] = 1'b0;
      end
   end

   // Register read mux.
   logic [evtmr_pkg::DATA_W-1:0] timer_rd;
   logic [evtmr_pkg::DATA_W-1:0] reg_rd;

   always_comb begin
      timer_rd = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (timer_hit_sel[i]) begin
            unique case (sub)
               evtmr_pkg::SUB_CONFIG:  timer_rd = timer_status[i].cfg_word;
               evtmr_pkg::SUB_COMPARE: timer_rd = timer_status[i].compare;
               default:                timer_rd = '0;
            endcase
         end
      end
   end

   always_comb begin
      reg_rd = '0;
      priority if (word == evtmr_pkg::W_CAPS) begin
         reg_rd[63:32] = {{(32 - evtmr_pkg::PERIOD_W){1'b0}}, tick_period_ff};
         reg_rd[evtmr_pkg::CAPS_LAST_LSB +: evtmr_pkg::TIMER_SEL_W] = LAST_TIMER;
      end else if (word == evtmr_pkg::W_GCONF) begin
         reg_rd[evtmr_pkg::GCONF_EN_BIT]     = global_enable_ff;
         reg_rd[evtmr_pkg::GCONF_LEGACY_BIT] = legacy_route_ff;
      end else if (word == evtmr_pkg::W_COUNT) begin
         reg_rd = main_count_ff;
      end else begin
         reg_rd = timer_rd;
      end
   end

   always_comb begin
      rsp_data_in.read_value = do_read ? reg_rd : '0;
      rsp_data_in.fired_mask = fired;
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff   <= evtmr_pkg::TICK_PERIOD_RESET;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         global_enable_ff <= 1'b0;
         legacy_route_ff  <= 1'b0;
         main_count_ff    <= '0;
      end else begin
         tick_period_ff   <= tick_period_in;
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         global_enable_ff <= global_enable_in;
         legacy_route_ff  <= legacy_route_in;
         main_count_ff    <= main_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Assertions.
   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      do_tick |=> (main_count_ff == $past(main_count_ff) + 64'd1))
      else $error("main counter did not advance on an enabled tick beat");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      (!do_tick && !(do_write && (word == evtmr_pkg::W_COUNT))) |=> $stable(main_count_ff))
      else $error("main counter changed without a tick or counter write");

   a_read_only_value: assert property (@(posedge clock) disable iff (reset)
      (advance && !do_read) |=> (rsp_data.read_value == '0))
      else $error("non-read beat returned a nonzero read value");

   a_fire_on_tick: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_data_ff.func != evtmr_pkg::FUNC_TICK)) |=> (rsp_data.fired_mask == '0))
      else $error("fired mask set on a beat that was not a tick");

endmodule
